FILE: hw/rtl/icpcf_pkg.sv
// Shared types and constants for the ICP correspondence filter and refiner.
// Holds the beat structs, register and verdict codes, and the fixed-point widths.
// No dependencies.
package icpcf_pkg;

  localparam int COORD_FRAC_BITS  = 16;
  localparam int NORMAL_FRAC_BITS = 14;

  localparam int COORD_W = 32;
  localparam int NORM_W  = 16;
  localparam int SQ_W    = 63;
  localparam int CFG_W   = 63;

  // The rounding divider: the numerator is |d.n| scaled up plus half the divisor,
  // the divisor is |n|^2, and the quotient magnitude stays below 2^(34+NORMAL_FRAC_BITS).
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_QUO_W = 34 + NORMAL_FRAC_BITS;

  localparam int COS45_Q14 = 11585;

  localparam logic [SQ_W-1:0] DIST_THR_RESET = SQ_W'(1) << (2 * COORD_FRAC_BITS - 2);
  localparam logic [NORM_W-1:0] COS_THR_RESET =
    NORM_W'(((COS45_Q14 << NORMAL_FRAC_BITS) + 8192) >> 14);
  localparam logic [SQ_W-1:0] SQ_MAX = '1;

  typedef enum logic [1:0] {
    CFG_DIST_THR       = 2'd0,
    CFG_COS_THR        = 2'd1,
    CFG_PROJ_MODE      = 2'd2,
    CFG_BOUNDARY_CHECK = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    VERDICT_KEPT     = 2'd0,
    VERDICT_TOO_FAR  = 2'd1,
    VERDICT_ANGLE    = 2'd2,
    VERDICT_BOUNDARY = 2'd3
  } verdict_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] src_x;
    logic signed [COORD_W-1:0] src_y;
    logic signed [COORD_W-1:0] src_z;
    logic signed [COORD_W-1:0] tgt_x;
    logic signed [COORD_W-1:0] tgt_y;
    logic signed [COORD_W-1:0] tgt_z;
    logic [3*NORM_W-1:0]       src_normal;
    logic [3*NORM_W-1:0]       tgt_normal;
    logic                      tgt_is_boundary;
  } item_t;

  typedef struct packed {
    verdict_t                  verdict;
    logic signed [COORD_W-1:0] proj_x;
    logic signed [COORD_W-1:0] proj_y;
    logic signed [COORD_W-1:0] proj_z;
    logic [SQ_W-1:0]           square_error;
  } result_t;

endpackage

FILE: hw/rtl/icp_correspondence_filter_refine_top.sv
// Top level of the ICP correspondence filter and refiner.
// Depends on icpcf_pkg and icpcf_div.
//
// One beat on the item channel carries a matched point pair; exactly one beat on the
// result channel answers it, in order. The block is a single pipeline that takes a new
// pair in every cycle while it is not held, with 6 front stages for the distance and
// normal tests, 34 + NORMAL_FRAC_BITS = 48 stages of the rounding divider that forms
// the plane projection scale, 5 back stages and the output register. A pair that is
// rejected still passes through all stages and comes out with zero coordinates and
// zero error. The whole pipeline advances together; it holds only while a result sits
// in the output register and the result side stalls, and then the item side is
// stalled as well. Configuration writes are registered and must only be made while no
// pair is in flight.
module icp_correspondence_filter_refine_top #(
  parameter int DIV_NUM_W = icpcf_pkg::DIV_NUM_W,
  parameter int DIV_DEN_W = icpcf_pkg::DIV_DEN_W,
  parameter int DIV_QUO_W = icpcf_pkg::DIV_QUO_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  icpcf_pkg::cfg_index_t         cfg_index,
  input  logic [icpcf_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  icpcf_pkg::item_t              item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output icpcf_pkg::result_t            result
);

  localparam int CW   = icpcf_pkg::COORD_W;
  localparam int NW   = icpcf_pkg::NORM_W;
  localparam int NFB  = icpcf_pkg::NORMAL_FRAC_BITS;
  localparam int PROD_W = DIV_QUO_W + NW;
  localparam int RND_W  = PROD_W + 1 - NFB;

  typedef struct packed {
    icpcf_pkg::verdict_t       verdict;
    logic                      dn_neg;
    logic                      a_zero;
    logic [2:0][CW-1:0]        src;
    logic [2:0][CW-1:0]        tgt;
    logic [2:0][NW-1:0]        nt;
  } tag_t;

  // Configuration registers.
  logic [icpcf_pkg::SQ_W-1:0] dist_thr;
  logic signed [NW-1:0]       cos_thr;
  logic                       proj_mode;
  logic                       bnd_check;
  logic [30:0]                cos_sq;
  logic signed [31:0]         cos_sq_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_thr  <= icpcf_pkg::DIST_THR_RESET;
      cos_thr   <= icpcf_pkg::COS_THR_RESET;
      proj_mode <= 1'b0;
      bnd_check <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        icpcf_pkg::CFG_DIST_THR:       dist_thr  <= cfg_data[icpcf_pkg::SQ_W-1:0];
        icpcf_pkg::CFG_COS_THR:        cos_thr   <= cfg_data[NW-1:0];
        icpcf_pkg::CFG_PROJ_MODE:      proj_mode <= cfg_data[0];
        icpcf_pkg::CFG_BOUNDARY_CHECK: bnd_check <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The squared threshold only follows the register, so it is kept registered.
  assign cos_sq_full = cos_thr * cos_thr;
  always_ff @(posedge clk) begin
    cos_sq <= cos_sq_full[30:0];
  end

  // The whole pipeline moves unless a finished beat is held at the output.
  logic adv;
  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;

  // Stage 1: unpack, coordinate differences.
  logic                 v1;
  logic signed [CW-1:0] s1_src [3];
  logic signed [CW-1:0] s1_tgt [3];
  logic signed [CW:0]   s1_d   [3];
  logic signed [NW-1:0] s1_ns  [3];
  logic signed [NW-1:0] s1_nt  [3];
  logic                 s1_bnd;
  logic signed [CW-1:0] in_src [3];
  logic signed [CW-1:0] in_tgt [3];

  assign in_src[0] = item.src_x;
  assign in_src[1] = item.src_y;
  assign in_src[2] = item.src_z;
  assign in_tgt[0] = item.tgt_x;
  assign in_tgt[1] = item.tgt_y;
  assign in_tgt[2] = item.tgt_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_src[i] <= in_src[i];
        s1_tgt[i] <= in_tgt[i];
        s1_d[i]   <= $signed({in_src[i][CW-1], in_src[i]}) -
                     $signed({in_tgt[i][CW-1], in_tgt[i]});
        s1_ns[i]  <= item.src_normal[(2-i)*NW +: NW];
        s1_nt[i]  <= item.tgt_normal[(2-i)*NW +: NW];
      end
      s1_bnd <= item.tgt_is_boundary;
    end
  end

  // Stage 2: lane products.
  logic                 v2;
  logic signed [CW-1:0] s2_src  [3];
  logic signed [CW-1:0] s2_tgt  [3];
  logic signed [NW-1:0] s2_nt   [3];
  logic [63:0]          s2_dsq  [3];
  logic signed [31:0]   s2_dotp [3];
  logic signed [31:0]   s2_nap  [3];
  logic signed [31:0]   s2_nbp  [3];
  logic signed [48:0]   s2_dnp  [3];
  logic                 s2_bnd;
  logic signed [65:0]   d_sq    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) d_sq[i] = s1_d[i] * s1_d[i];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s2_src[i]  <= s1_src[i];
        s2_tgt[i]  <= s1_tgt[i];
        s2_nt[i]   <= s1_nt[i];
        s2_dsq[i]  <= d_sq[i][63:0];
        s2_dotp[i] <= s1_ns[i] * s1_nt[i];
        s2_nap[i]  <= s1_ns[i] * s1_ns[i];
        s2_nbp[i]  <= s1_nt[i] * s1_nt[i];
        s2_dnp[i]  <= s1_d[i] * s1_nt[i];
      end
      s2_bnd <= s1_bnd;
    end
  end

  // Stage 3: sums across the three axes.
  logic                       v3;
  logic signed [CW-1:0]       s3_src [3];
  logic signed [CW-1:0]       s3_tgt [3];
  logic signed [NW-1:0]       s3_nt  [3];
  logic [icpcf_pkg::SQ_W-1:0] s3_dist;
  logic signed [33:0]         s3_dot;
  logic [31:0]                s3_na;
  logic [31:0]                s3_nb;
  logic signed [50:0]         s3_dn;
  logic                       s3_bnd;
  logic [65:0]                dist_sum;
  logic signed [33:0]         na_sum;
  logic signed [33:0]         nb_sum;

  assign dist_sum = 66'(s2_dsq[0]) + 66'(s2_dsq[1]) + 66'(s2_dsq[2]);
  assign na_sum   = s2_nap[0] + s2_nap[1] + s2_nap[2];
  assign nb_sum   = s2_nbp[0] + s2_nbp[1] + s2_nbp[2];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s3_src[i] <= s2_src[i];
        s3_tgt[i] <= s2_tgt[i];
        s3_nt[i]  <= s2_nt[i];
      end
      s3_dist <= (dist_sum > 66'(icpcf_pkg::SQ_MAX)) ? icpcf_pkg::SQ_MAX
                                                       : dist_sum[icpcf_pkg::SQ_W-1:0];
      s3_dot  <= s2_dotp[0] + s2_dotp[1] + s2_dotp[2];
      s3_na   <= na_sum[31:0];
      s3_nb   <= nb_sum[31:0];
      s3_dn   <= s2_dnp[0] + s2_dnp[1] + s2_dnp[2];
      s3_bnd  <= s2_bnd;
    end
  end

  // Stage 4: distance test, squares for the angle test, divider operands.
  logic                 v4;
  logic signed [CW-1:0] s4_src [3];
  logic signed [CW-1:0] s4_tgt [3];
  logic signed [NW-1:0] s4_nt  [3];
  logic                 s4_too_far;
  logic [63:0]          s4_dot_sq;
  logic [63:0]          s4_nanb;
  logic                 s4_dot_pos;
  logic                 s4_dot_neg;
  logic                 s4_nzero;
  logic [DIV_NUM_W-1:0] s4_num;
  logic [DIV_DEN_W-1:0] s4_den;
  logic                 s4_dn_neg;
  logic                 s4_a_zero;
  logic                 s4_bnd;
  logic signed [67:0]   dot_sq_full;
  logic [50:0]          dn_abs;

  assign dot_sq_full = s3_dot * s3_dot;
  assign dn_abs      = s3_dn[50] ? 51'(-s3_dn) : 51'(s3_dn);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s4_src[i] <= s3_src[i];
        s4_tgt[i] <= s3_tgt[i];
        s4_nt[i]  <= s3_nt[i];
      end
      s4_too_far <= s3_dist >= dist_thr;
      s4_dot_sq  <= dot_sq_full[63:0];
      s4_nanb    <= 64'(s3_na) * 64'(s3_nb);
      s4_dot_pos <= !s3_dot[33] && (s3_dot != '0);
      s4_dot_neg <= s3_dot[33];
      s4_nzero   <= (s3_na == '0) || (s3_nb == '0);
      // Half the divisor is added up front so the quotient rounds to nearest.
      s4_num     <= (DIV_NUM_W'(dn_abs) << NFB) + DIV_NUM_W'(s3_nb >> 1);
      s4_den     <= (s3_nb == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(s3_nb);
      s4_dn_neg  <= s3_dn[50];
      s4_a_zero  <= s3_nb == '0;
      s4_bnd     <= s3_bnd;
    end
  end

  // Stage 5: the threshold side of the angle test, split in two 32-bit halves.
  logic                 v5;
  logic signed [CW-1:0] s5_src [3];
  logic signed [CW-1:0] s5_tgt [3];
  logic signed [NW-1:0] s5_nt  [3];
  logic                 s5_too_far;
  logic [63:0]          s5_dot_sq;
  logic [62:0]          s5_rhs_lo;
  logic [62:0]          s5_rhs_hi;
  logic                 s5_dot_pos;
  logic                 s5_dot_neg;
  logic                 s5_nzero;
  logic [DIV_NUM_W-1:0] s5_num;
  logic [DIV_DEN_W-1:0] s5_den;
  logic                 s5_dn_neg;
  logic                 s5_a_zero;
  logic                 s5_bnd;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s5_src[i] <= s4_src[i];
        s5_tgt[i] <= s4_tgt[i];
        s5_nt[i]  <= s4_nt[i];
      end
      s5_too_far <= s4_too_far;
      s5_dot_sq  <= s4_dot_sq;
      s5_rhs_lo  <= 63'(cos_sq) * 63'(s4_nanb[31:0]);
      s5_rhs_hi  <= 63'(cos_sq) * 63'(s4_nanb[63:32]);
      s5_dot_pos <= s4_dot_pos;
      s5_dot_neg <= s4_dot_neg;
      s5_nzero   <= s4_nzero;
      s5_num     <= s4_num;
      s5_den     <= s4_den;
      s5_dn_neg  <= s4_dn_neg;
      s5_a_zero  <= s4_a_zero;
      s5_bnd     <= s4_bnd;
    end
  end

  // Stage 6: exact angle test by comparing squares, then the verdict.
  logic                v6;
  tag_t                s6_tag;
  logic [DIV_NUM_W-1:0] s6_num;
  logic [DIV_DEN_W-1:0] s6_den;
  logic [95:0]         lhs;
  logic [95:0]         rhs;
  logic                c_neg;
  logic                normals_ok;
  icpcf_pkg::verdict_t verdict_next;

  assign lhs   = 96'(s5_dot_sq) << (2 * NFB);
  assign rhs   = (96'(s5_rhs_hi) << 32) + 96'(s5_rhs_lo);
  assign c_neg = cos_thr[NW-1];

  always_comb begin
    // A zero normal gives a zero cosine. When the signs of the dot product and the
    // threshold already settle the test, no magnitude compare is needed.
    if (s5_nzero) begin
      normals_ok = c_neg;
    end else if (!s5_dot_neg && c_neg) begin
      normals_ok = 1'b1;
    end else if (!s5_dot_pos && !c_neg) begin
      normals_ok = 1'b0;
    end else if (s5_dot_pos) begin
      normals_ok = lhs > rhs;
    end else begin
      normals_ok = lhs < rhs;
    end

    if (s5_too_far) begin
      verdict_next = icpcf_pkg::VERDICT_TOO_FAR;
    end else if (!normals_ok) begin
      verdict_next = icpcf_pkg::VERDICT_ANGLE;
    end else if (bnd_check && s5_bnd) begin
      verdict_next = icpcf_pkg::VERDICT_BOUNDARY;
    end else begin
      verdict_next = icpcf_pkg::VERDICT_KEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_tag.verdict <= verdict_next;
      s6_tag.dn_neg  <= s5_dn_neg;
      s6_tag.a_zero  <= s5_a_zero;
      for (int i = 0; i < 3; i++) begin
        s6_tag.src[i] <= s5_src[i];
        s6_tag.tgt[i] <= s5_tgt[i];
        s6_tag.nt[i]  <= s5_nt[i];
      end
      s6_num <= s5_num;
      s6_den <= s5_den;
    end
  end

  // Divider: the projection scale |d.n| * 2^NFB / |n|^2.
  logic                 vd;
  logic [DIV_QUO_W-1:0] div_quo;
  logic [$bits(tag_t)-1:0] div_tag_bits;
  tag_t                 div_tag;

  icpcf_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .QUO_W (DIV_QUO_W),
    .TAG_W ($bits(tag_t))
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (v6),
    .num     (s6_num),
    .den     (s6_den),
    .tag_in  (s6_tag),
    .out_vld (vd),
    .quo     (div_quo),
    .tag_out (div_tag_bits)
  );

  assign div_tag = tag_t'(div_tag_bits);

  // Back stage 1: scale times normal, on magnitudes with the sign kept aside.
  logic                 p1_v;
  tag_t                 p1_tag;
  logic [PROD_W-1:0]    p1_m   [3];
  logic                 p1_neg [3];
  logic [NW-1:0]        nt_abs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nt_abs[i] = div_tag.nt[i][NW-1] ? NW'(-div_tag.nt[i]) : div_tag.nt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_tag <= div_tag;
      for (int i = 0; i < 3; i++) begin
        p1_m[i]   <= PROD_W'(div_quo) * PROD_W'(nt_abs[i]);
        p1_neg[i] <= div_tag.dn_neg ^ div_tag.nt[i][NW-1];
      end
    end
  end

  // Back stage 2: round the product back to coordinate scale, ties away from zero.
  logic              p2_v;
  tag_t              p2_tag;
  logic [RND_W-1:0]  p2_r   [3];
  logic              p2_neg [3];
  logic [PROD_W:0]   rnd_sum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd_sum[i] = (PROD_W+1)'(p1_m[i]) + ((PROD_W+1)'(1) << (NFB - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_tag <= p1_tag;
      for (int i = 0; i < 3; i++) begin
        p2_r[i]   <= RND_W'(rnd_sum[i] >> NFB);
        p2_neg[i] <= p1_neg[i];
      end
    end
  end

  // Back stage 3: subtract from the query point, saturate, pick the refined target.
  logic                 p3_v;
  icpcf_pkg::verdict_t  p3_verdict;
  logic signed [CW-1:0] p3_src [3];
  logic signed [CW-1:0] p3_p   [3];
  logic signed [RND_W+1:0] proj_wide [3];
  logic signed [CW-1:0] proj_sat [3];
  logic signed [CW-1:0] proj_sel [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p2_neg[i]) begin
        proj_wide[i] = $signed((RND_W+2)'($signed(p2_tag.src[i]))) +
                       $signed({2'b00, p2_r[i]});
      end else begin
        proj_wide[i] = $signed((RND_W+2)'($signed(p2_tag.src[i]))) -
                       $signed({2'b00, p2_r[i]});
      end
      if ((proj_wide[i][RND_W+1:CW-1] == '0) || (proj_wide[i][RND_W+1:CW-1] == '1)) begin
        proj_sat[i] = proj_wide[i][CW-1:0];
      end else if (proj_wide[i][RND_W+1]) begin
        proj_sat[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        proj_sat[i] = {1'b0, {(CW-1){1'b1}}};
      end
      if (!proj_mode) begin
        proj_sel[i] = p2_tag.tgt[i];
      end else if (p2_tag.a_zero) begin
        proj_sel[i] = p2_tag.src[i];
      end else begin
        proj_sel[i] = proj_sat[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_verdict <= p2_tag.verdict;
      for (int i = 0; i < 3; i++) begin
        p3_src[i] <= p2_tag.src[i];
        p3_p[i]   <= proj_sel[i];
      end
    end
  end

  // Back stage 4: residual from the query to the refined target.
  logic                 p4_v;
  icpcf_pkg::verdict_t  p4_verdict;
  logic signed [CW-1:0] p4_p [3];
  logic signed [CW:0]   p4_e [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_verdict <= p3_verdict;
      for (int i = 0; i < 3; i++) begin
        p4_p[i] <= p3_p[i];
        p4_e[i] <= $signed({p3_src[i][CW-1], p3_src[i]}) -
                   $signed({p3_p[i][CW-1], p3_p[i]});
      end
    end
  end

  // Back stage 5: squared residuals.
  logic                 p5_v;
  icpcf_pkg::verdict_t  p5_verdict;
  logic signed [CW-1:0] p5_p   [3];
  logic [63:0]          p5_esq [3];
  logic signed [65:0]   e_sq   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) e_sq[i] = p4_e[i] * p4_e[i];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_verdict <= p4_verdict;
      for (int i = 0; i < 3; i++) begin
        p5_p[i]   <= p4_p[i];
        p5_esq[i] <= e_sq[i][63:0];
      end
    end
  end

  // Output register: saturating error sum; a rejected pair reports zeros.
  logic [65:0] err_sum;
  logic        kept;

  assign err_sum = 66'(p5_esq[0]) + 66'(p5_esq[1]) + 66'(p5_esq[2]);
  assign kept    = p5_verdict == icpcf_pkg::VERDICT_KEPT;

  always_ff @(posedge clk) begin
    if (adv) begin
      result.verdict <= p5_verdict;
      result.proj_x  <= kept ? p5_p[0] : '0;
      result.proj_y  <= kept ? p5_p[1] : '0;
      result.proj_z  <= kept ? p5_p[2] : '0;
      if (!kept) begin
        result.square_error <= '0;
      end else if (err_sum > 66'(icpcf_pkg::SQ_MAX)) begin
        result.square_error <= icpcf_pkg::SQ_MAX;
      end else begin
        result.square_error <= err_sum[icpcf_pkg::SQ_W-1:0];
      end
    end
  end

  // Valid bits travel with the beats.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      v6           <= 1'b0;
      p1_v         <= 1'b0;
      p2_v         <= 1'b0;
      p3_v         <= 1'b0;
      p4_v         <= 1'b0;
      p5_v         <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v1           <= item_valid;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      v5           <= v4;
      v6           <= v5;
      p1_v         <= vd;
      p2_v         <= p1_v;
      p3_v         <= p2_v;
      p4_v         <= p3_v;
      p5_v         <= p4_v;
      result_valid <= p5_v;
    end
  end

endmodule

FILE: hw/rtl/icpcf_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a tag that rides along.
// Depends on icpcf_pkg for the default widths.
module icpcf_div #(
  parameter int NUM_W = icpcf_pkg::DIV_NUM_W,
  parameter int DEN_W = icpcf_pkg::DIV_DEN_W,
  parameter int QUO_W = icpcf_pkg::DIV_QUO_W,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_vld,
  output logic [QUO_W-1:0] quo,
  output logic [TAG_W-1:0] tag_out
);

  logic             vld_q  [QUO_W];
  logic [DEN_W-1:0] rem_q  [QUO_W];
  logic [QUO_W-1:0] low_q  [QUO_W];
  logic [QUO_W-1:0] quo_q  [QUO_W];
  logic [DEN_W-1:0] den_q  [QUO_W];
  logic [TAG_W-1:0] tag_q  [QUO_W];

  logic [DEN_W-1:0] rem_in [QUO_W];
  logic [QUO_W-1:0] low_in [QUO_W];
  logic [QUO_W-1:0] quo_in [QUO_W];
  logic [DEN_W-1:0] den_in [QUO_W];
  logic [DEN_W:0]   trial  [QUO_W];
  logic             ge     [QUO_W];
  logic [DEN_W-1:0] rem_next [QUO_W];
  logic [QUO_W-1:0] low_next [QUO_W];
  logic [QUO_W-1:0] quo_next [QUO_W];

  // The quotient fits in QUO_W bits, so the bits above them are already below den.
  always_comb begin
    rem_in[0] = DEN_W'(num >> QUO_W);
    low_in[0] = num[QUO_W-1:0];
    quo_in[0] = '0;
    den_in[0] = den;
    for (int k = 1; k < QUO_W; k++) begin
      rem_in[k] = rem_q[k-1];
      low_in[k] = low_q[k-1];
      quo_in[k] = quo_q[k-1];
      den_in[k] = den_q[k-1];
    end
    for (int k = 0; k < QUO_W; k++) begin
      trial[k]    = {rem_in[k], low_in[k][QUO_W-1]};
      ge[k]       = trial[k] >= {1'b0, den_in[k]};
      rem_next[k] = ge[k] ? DEN_W'(trial[k] - {1'b0, den_in[k]}) : DEN_W'(trial[k]);
      low_next[k] = low_in[k] << 1;
      quo_next[k] = {quo_in[k][QUO_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QUO_W; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_vld;
      for (int k = 1; k < QUO_W; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_q[0] <= tag_in;
      den_q[0] <= den;
      for (int k = 1; k < QUO_W; k++) begin
        tag_q[k] <= tag_q[k-1];
        den_q[k] <= den_q[k-1];
      end
      for (int k = 0; k < QUO_W; k++) begin
        rem_q[k] <= rem_next[k];
        low_q[k] <= low_next[k];
        quo_q[k] <= quo_next[k];
      end
    end
  end

  assign out_vld = vld_q[QUO_W-1];
  assign quo     = quo_q[QUO_W-1];
  assign tag_out = tag_q[QUO_W-1];

endmodule
